@@ rtl/core/sorted_range_table_lookup_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted range table lookup block.
// Each macro expands to a clocked concurrent assertion that is disabled
// while reset is asserted, or to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_RANGE_TABLE_LOOKUP_ASSERT_SVH
`define SORTED_RANGE_TABLE_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define SRTL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("srtl assertion failed");
`define SRTL_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define SRTL_ASSERT(lbl, clk, rst_n, prop)
`define SRTL_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif
`endif

@@ rtl/core/srtl_pkg.sv @@
// ----------------------------------------------------------------------------
// srtl_pkg
// Types and constants shared by the sorted range table lookup modules.
// ----------------------------------------------------------------------------
package srtl_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_OVERLAP  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_FALLBACK = 3'd4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] code_low;
    logic signed [31:0] code_high;
  } srtl_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] match_index;
    logic [6:0] entry_count;
  } srtl_rsp_t;

  // Range under test, broadcast to every cell.
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } srtl_cmd_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } srtl_ctl_t;

endpackage

@@ rtl/core/srtl_cell.sv @@
// ----------------------------------------------------------------------------
// srtl_cell
// One table entry. Compares its range against the broadcast range and, on
// insert, keeps its entry or takes the new range or its left neighbor's.
// ----------------------------------------------------------------------------
module srtl_cell #(
  parameter int unsigned DEPTH = srtl_pkg::DefaultDepth,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srtl_pkg::srtl_ctl_t ctl_i,
  input  srtl_pkg::srtl_cmd_t cmd_i,
  input  logic [CW-1:0]       count_i,
  input  logic signed [31:0]  prev_low_i,
  input  logic signed [31:0]  prev_high_i,
  input  logic                prev_ge_i,
  output logic signed [31:0]  low_o,
  output logic signed [31:0]  high_o,
  output logic                ge_o,
  output logic                hit_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic signed [31:0] low_q, high_q;
  logic               ge_q, hit_q;
  logic               occupied;

  assign occupied = MyIdx < count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_q  <= 1'b0;
      hit_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      ge_q  <= occupied && (cmd_i.lo >= low_q);
      hit_q <= occupied && (cmd_i.lo <= high_q) && (cmd_i.hi >= low_q);
    end
  end

  // Entries at or past the insert position move one place right; the cell at
  // the insert position takes the new range.
  always_ff @(posedge clk_i) begin
    if (ctl_i.upd_en && !ge_q && (MyIdx <= count_i)) begin
      if ((IDX == 0) || prev_ge_i) begin
        low_q  <= cmd_i.lo;
        high_q <= cmd_i.hi;
      end else begin
        low_q  <= prev_low_i;
        high_q <= prev_high_i;
      end
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;
  assign ge_o   = ge_q;
  assign hit_o  = hit_q;

endmodule

@@ rtl/core/srtl_chain.sv @@
// ----------------------------------------------------------------------------
// srtl_chain
// The row of table cells, linked left to right, and the reduction of their
// hit flags into a match flag and a match position.
// ----------------------------------------------------------------------------
module srtl_chain #(
  parameter int unsigned DEPTH = srtl_pkg::DefaultDepth,
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srtl_pkg::srtl_ctl_t ctl_i,
  input  srtl_pkg::srtl_cmd_t cmd_i,
  input  logic [CW-1:0]       count_i,
  output logic                hit_any_o,
  output logic [IW-1:0]       hit_idx_o
);

  logic signed [31:0] low_w  [DEPTH];
  logic signed [31:0] high_w [DEPTH];
  logic [DEPTH-1:0]   ge_w;
  logic [DEPTH-1:0]   hit_w;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] p_low, p_high;
    logic               p_ge;
    if (g == 0) begin : g_first
      assign p_low  = '0;
      assign p_high = '0;
      assign p_ge   = 1'b0;
    end else begin : g_next
      assign p_low  = low_w[g-1];
      assign p_high = high_w[g-1];
      assign p_ge   = ge_w[g-1];
    end
    srtl_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .cmd_i       (cmd_i),
      .count_i     (count_i),
      .prev_low_i  (p_low),
      .prev_high_i (p_high),
      .prev_ge_i   (p_ge),
      .low_o       (low_w[g]),
      .high_o      (high_w[g]),
      .ge_o        (ge_w[g]),
      .hit_o       (hit_w[g])
    );
  end

  // Stored ranges never overlap, so a lookup hits at most one cell and the
  // position can be formed by OR-ing the masked indexes.
  always_comb begin
    hit_idx_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_w[i]) begin
        hit_idx_o = hit_idx_o | IW'(i);
      end
    end
  end

  assign hit_any_o = |hit_w;

endmodule

@@ rtl/core/sorted_range_table_lookup.sv @@
// ----------------------------------------------------------------------------
// sorted_range_table_lookup
// Table of non-overlapping signed code ranges kept sorted in a chain of cells.
// A result is registered on the output after the compare phase of the cells
// and their update phase; a new request is taken as the update phase ends,
// and output stalls hold the update phase.
// Reset: the entry count and fallback enable clear; stored bounds do not.
// ----------------------------------------------------------------------------
`include "sorted_range_table_lookup_assert.svh"

module sorted_range_table_lookup #(
  parameter int unsigned TABLE_DEPTH = srtl_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srtl_pkg::srtl_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srtl_pkg::srtl_rsp_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMP,
    PH_UPD
  } phase_e;

  phase_e              phase_q;
  logic                lookup_q;
  srtl_pkg::srtl_cmd_t cmd_q;
  logic [CW-1:0]       count_q;
  logic                fallback_q;
  logic                out_valid_q;
  srtl_pkg::srtl_rsp_t out_data_q;

  srtl_pkg::srtl_ctl_t ctl;
  logic                hit_any;
  logic [IW-1:0]       hit_idx;
  logic                out_free;
  logic                finish;
  logic                accept;
  logic                do_insert;
  srtl_pkg::srtl_rsp_t rsp;
  srtl_pkg::srtl_cmd_t new_cmd;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (phase_q == PH_UPD) && out_free;
  assign in_stall_o = (phase_q != PH_IDLE) && !finish;
  assign accept     = in_valid_i && !in_stall_o;

  assign do_insert  = finish && !lookup_q && !hit_any && (count_q < Full);
  assign ctl.cmp_en = (phase_q == PH_CMP);
  assign ctl.upd_en = do_insert;

  // A lookup tests the single-code range [code, code].
  always_comb begin
    new_cmd.lo = in_data_i.code_low;
    new_cmd.hi = in_data_i.code_high;
    if (in_data_i.req_type == srtl_pkg::REQ_LOOKUP) begin
      new_cmd.hi = in_data_i.code_low;
    end else if (in_data_i.code_low > in_data_i.code_high) begin
      new_cmd.lo = in_data_i.code_high;
      new_cmd.hi = in_data_i.code_low;
    end
  end

  always_comb begin
    rsp.status      = srtl_pkg::ST_INSERTED;
    rsp.match_index = '0;
    rsp.entry_count = 7'(count_q);
    if (lookup_q) begin
      if (hit_any) begin
        rsp.status      = srtl_pkg::ST_FOUND;
        rsp.match_index = 7'(hit_idx);
      end else begin
        rsp.status = srtl_pkg::ST_FALLBACK;
        if (fallback_q) begin
          rsp.match_index = 7'(count_q);
        end
      end
    end else if (hit_any) begin
      rsp.status = srtl_pkg::ST_OVERLAP;
    end else if (count_q >= Full) begin
      rsp.status = srtl_pkg::ST_FULL;
    end else begin
      rsp.entry_count = 7'(count_q + CW'(1));
    end
  end

  srtl_chain #(
    .DEPTH (TABLE_DEPTH)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .cmd_i     (cmd_q),
    .count_i   (count_q),
    .hit_any_o (hit_any),
    .hit_idx_o (hit_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (phase_q)
        PH_IDLE: begin
          if (accept) begin
            phase_q <= PH_CMP;
          end
        end
        PH_CMP: begin
          phase_q <= PH_UPD;
        end
        PH_UPD: begin
          if (finish) begin
            phase_q <= accept ? PH_CMP : PH_IDLE;
            if (do_insert) begin
              count_q <= count_q + CW'(1);
            end
          end
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lookup_q <= (in_data_i.req_type == srtl_pkg::REQ_LOOKUP);
      cmd_q    <= new_cmd;
    end
    if (finish) begin
      out_data_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fallback_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SRTL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= Full)
  `SRTL_ASSERT_MSG(a_accept_busy, clk_i, rst_ni, accept |=> in_stall_o,
                   "accepted transaction did not block the input")
  `SRTL_ASSERT(a_out_from_upd, clk_i, rst_ni,
               $rose(out_valid_q) |-> $past(phase_q == PH_UPD))
  `SRTL_ASSERT_MSG(a_count_step, clk_i, rst_ni,
                   (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)),
                   "entry count moved by more than one")

endmodule

@@ verif/srtl_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srtl_table_checker
// Watches the request, response and configuration channels of the sorted
// range table. It keeps its own copy of the range table and fallback setting,
// works out the response of every accepted request, and compares each
// accepted response field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module srtl_table_checker #(
  parameter int unsigned DEPTH = srtl_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  srtl_pkg::srtl_req_t in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  srtl_pkg::srtl_rsp_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         rsp_owed_o,
  output int unsigned         checked_o,
  output int unsigned         inserted_o,
  output int unsigned         overlap_o,
  output int unsigned         full_o,
  output int unsigned         found_o,
  output int unsigned         miss_o
);

  logic signed [31:0] lo_tbl [DEPTH];
  logic signed [31:0] hi_tbl [DEPTH];
  int                 n_ranges;
  logic               fallback_on;

  srtl_pkg::srtl_rsp_t table_rsp_q [$];
  int unsigned fails    = 0;
  int unsigned owed     = 0;
  int unsigned checked  = 0;
  int unsigned inserted = 0;
  int unsigned overlap  = 0;
  int unsigned full     = 0;
  int unsigned found    = 0;
  int unsigned miss     = 0;

  assign fail_count_o = fails;
  assign rsp_owed_o   = owed;
  assign checked_o    = checked;
  assign inserted_o   = inserted;
  assign overlap_o    = overlap;
  assign full_o       = full;
  assign found_o      = found;
  assign miss_o       = miss;

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= 40) $display("%0t ns: MISMATCH %s", $time, what);
  endtask

  // Applies one request to the local table and returns the response it owes.
  function automatic srtl_pkg::srtl_rsp_t apply_table_request(
      input srtl_pkg::srtl_req_t req);
    srtl_pkg::srtl_rsp_t rsp;
    logic signed [31:0]  lo;
    logic signed [31:0]  hi;
    logic signed [31:0]  tmp;
    int                  pos;
    logic                hit;
    rsp = '0;
    lo  = req.code_low;
    hi  = req.code_high;
    hit = 1'b0;
    if (req.req_type == srtl_pkg::REQ_INSERT) begin
      if (lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      // Full interval test, so enclosing and enclosed ranges both collide.
      for (int i = 0; i < n_ranges; i++) begin
        if (lo <= hi_tbl[i] && hi >= lo_tbl[i]) hit = 1'b1;
      end
      if (hit) begin
        rsp.status = srtl_pkg::ST_OVERLAP;
      end else if (n_ranges >= int'(DEPTH)) begin
        rsp.status = srtl_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < n_ranges && lo >= lo_tbl[pos]) pos++;
        for (int i = n_ranges; i > pos; i--) begin
          lo_tbl[i] = lo_tbl[i-1];
          hi_tbl[i] = hi_tbl[i-1];
        end
        lo_tbl[pos] = lo;
        hi_tbl[pos] = hi;
        n_ranges++;
        rsp.status = srtl_pkg::ST_INSERTED;
      end
    end else begin
      for (int i = 0; i < n_ranges; i++) begin
        if (!hit && lo >= lo_tbl[i] && lo <= hi_tbl[i]) begin
          hit = 1'b1;
          rsp.match_index = 7'(i);
        end
      end
      if (hit) begin
        rsp.status = srtl_pkg::ST_FOUND;
      end else begin
        rsp.status      = srtl_pkg::ST_FALLBACK;
        rsp.match_index = fallback_on ? 7'(n_ranges) : 7'd0;
      end
    end
    rsp.entry_count = 7'(n_ranges);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    srtl_pkg::srtl_rsp_t want;
    srtl_pkg::srtl_rsp_t got;
    if (!rst_ni) begin
      n_ranges    = 0;
      fallback_on = 1'b0;
      table_rsp_q.delete();
      owed        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) fallback_on = cfg_data_i;

      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (table_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response with nothing owed: %p", got));
        end else begin
          want = table_rsp_q.pop_front();
          checked++;
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
          if (got.match_index !== want.match_index)
            report_mismatch($sformatf("match_index got %0d want %0d",
                                      got.match_index, want.match_index));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.entry_count, want.entry_count));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        want = apply_table_request(in_data_i);
        table_rsp_q.push_back(want);
        case (want.status)
          srtl_pkg::ST_INSERTED: inserted++;
          srtl_pkg::ST_OVERLAP:  overlap++;
          srtl_pkg::ST_FULL:     full++;
          srtl_pkg::ST_FOUND:    found++;
          default:               miss++;
        endcase
      end
      owed = table_rsp_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the sorted range table: a directed set of inserts and
// lookups at the code extremes and the boundary cases, then randomized phases
// that fill the table, run past full and toggle the fallback setting. Random
// gaps and output stalls, plus one long output hold, exercise backpressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned        TableDepth = srtl_pkg::DefaultDepth;
  localparam logic signed [31:0] CodeMin    = 32'sh8000_0000;
  localparam logic signed [31:0] CodeMax    = 32'sh7FFF_FFFF;
  localparam int unsigned        NumPhases  = 7;
  localparam int unsigned        PhaseItems = 200;
  localparam int unsigned        LongHold   = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  srtl_pkg::srtl_req_t in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  srtl_pkg::srtl_rsp_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  int unsigned fails;
  int unsigned owed;
  int unsigned checked;
  int unsigned n_inserted;
  int unsigned n_overlap;
  int unsigned n_full;
  int unsigned n_found;
  int unsigned n_miss;

  // Idle control shared with the response side.
  logic        tx_idle = 1'b1;
  logic        rx_idle = 1'b1;
  int unsigned hold_req_cnt = 0;

  logic signed [31:0] code_pool [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_range_table_lookup #(
    .TABLE_DEPTH(TableDepth)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  srtl_table_checker #(
    .DEPTH(TableDepth)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .rsp_owed_o   (owed),
    .checked_o    (checked),
    .inserted_o   (n_inserted),
    .overlap_o    (n_overlap),
    .full_o       (n_full),
    .found_o      (n_found),
    .miss_o       (n_miss)
  );

  function automatic srtl_pkg::srtl_req_t mk_req(input logic kind,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    srtl_pkg::srtl_req_t req;
    req.req_type  = kind;
    req.code_low  = lo;
    req.code_high = hi;
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_req(input srtl_pkg::srtl_req_t req);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Only written once every owed response is back and the block has settled.
  task automatic write_fallback(input logic en);
    in_valid = 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = en;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Response side: a random stall before each transaction while rx_idle is set, or one long hold on request.
  initial begin
    int unsigned hold;
    int unsigned hold_done;
    hold_done = 0;
    @(negedge clk);
    forever begin
      if (hold_req_cnt > hold_done) begin
        hold = LongHold;
        hold_done++;
      end else begin
        hold = rx_idle ? $urandom_range(0, 10) : 0;
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin
    srtl_pkg::srtl_req_t req;
    logic signed [31:0]  lo;
    logic signed [31:0]  hi;
    logic signed [31:0]  pick;
    logic                fb;
    int unsigned         roll;
    int unsigned         sel;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty table, reversed bounds, enclosing and enclosed ranges,
    // shared endpoints, single-code ranges at both extremes, misses.
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, 0, CodeMax));
    send_req(mk_req(srtl_pkg::REQ_INSERT, 100, 200));
    send_req(mk_req(srtl_pkg::REQ_INSERT, 300, 250));
    send_req(mk_req(srtl_pkg::REQ_INSERT, 50, 400));
    send_req(mk_req(srtl_pkg::REQ_INSERT, 120, 130));
    send_req(mk_req(srtl_pkg::REQ_INSERT, 200, 210));
    send_req(mk_req(srtl_pkg::REQ_INSERT, CodeMin, CodeMin));
    send_req(mk_req(srtl_pkg::REQ_INSERT, CodeMax, CodeMax));
    send_req(mk_req(srtl_pkg::REQ_INSERT, -500, -1000));
    send_req(mk_req(srtl_pkg::REQ_INSERT, 0, 0));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, CodeMin, 0));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, CodeMax, -1));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, 200, CodeMin));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, 250, 0));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, 201, 0));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, -1, 0));
    write_fallback(1'b1);
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, 201, 0));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, CodeMax - 1, 0));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, -700, 0));
    send_req(mk_req(srtl_pkg::REQ_LOOKUP, 0, 0));
    code_pool = '{100, 200, 250, 300, -1000, -500, 0};

    // Random phases. Inserts are partly aimed near earlier codes so that
    // overlaps keep coming once the table is full.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       fb = 1'b1;
        1:       fb = 1'b0;
        default: fb = 1'($urandom_range(0, 1));
      endcase
      write_fallback(fb);
      tx_idle = (ph != 2 && ph != 3);
      rx_idle = (ph != 2 && ph != 5);
      // Long output hold with back-to-back requests fills the block up.
      if (ph == 3) hold_req_cnt++;

      for (int n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        pick = code_pool[$urandom_range(0, code_pool.size() - 1)];
        if (roll < 35) begin
          if (sel < 40) begin
            lo = pick + ($signed($urandom_range(0, 100)) - 50);
            hi = lo + $signed($urandom_range(0, 100));
          end else if (sel < 95) begin
            lo = $urandom;
            hi = lo + $signed($urandom_range(0, 65535));
          end else begin
            lo = $urandom;
            hi = $urandom;
          end
          code_pool.push_back(lo);
          code_pool.push_back(hi);
          while (code_pool.size() > 256) void'(code_pool.pop_front());
          if ($urandom_range(0, 2) == 0) req = mk_req(srtl_pkg::REQ_INSERT, hi, lo);
          else req = mk_req(srtl_pkg::REQ_INSERT, lo, hi);
        end else begin
          if (sel < 70) lo = pick + ($signed($urandom_range(0, 4)) - 2);
          else if (sel < 75) lo = sel[0] ? CodeMax : CodeMin;
          else lo = $urandom;
          req = mk_req(srtl_pkg::REQ_LOOKUP, lo, $urandom);
        end
        send_req(req);
      end
    end

    in_valid = 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Summary: %0d transactions checked, %0d inserted, %0d overlaps, %0d full,",
             checked, n_inserted, n_overlap, n_full);
    $display("Summary: %0d lookups found, %0d unmatched, fallback toggled over %0d phases",
             n_found, n_miss, NumPhases);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d responses still owed", owed);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
